FILE: src/ttl_pkg.sv
// shared types, constants and trit helpers for the ternary linear layer engine
// no dependencies; used by every module of the block
package ttl_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 6;
    localparam int WADDR_W     = ROW_W + COL_W;
    localparam int LEN_W       = 7;
    localparam int CHG_W       = 13;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int PADDR_W     = 5;

    typedef logic signed [1:0] trit_t;

    typedef enum logic [1:0] {
        CMD_WR_WEIGHT = 2'd0,
        CMD_WR_BIAS   = 2'd1,
        CMD_INPUT     = 2'd2,
        CMD_HEBBIAN   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_INPUT_LENGTH  = 3'd0,
        REG_OUTPUT_LENGTH = 3'd1,
        REG_BIAS_ENABLE   = 3'd2,
        REG_TROPICAL_MODE = 3'd3,
        REG_LEARNING_RATE = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FWD_COL,
        ST_FWD_ROW,
        ST_FWD_OUT,
        ST_HEB_RUN,
        ST_HEB_OUT
    } state_t;

    // one decoded command as it sits in the queue
    typedef struct packed {
        cmd_t             cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        trit_t            trit;
        logic             last;
        logic             delta_zero;
        logic             delta_neg;
    } op_t;

    // active configuration, lengths already clamped
    typedef struct packed {
        logic [LEN_W-1:0] rows;
        logic [LEN_W-1:0] cols;
        logic             bias_en;
        logic             tropical;
        trit_t            rate;
    } cfg_t;

    // the pattern for -2 is its gf(3) equal, +1
    function automatic trit_t trit_decode(input logic [1:0] bits);
        trit_t t;
        t = (bits == 2'b10) ? trit_t'(2'sb01) : trit_t'(bits);
        return t;
    endfunction

    // balanced gf(3) add
    function automatic trit_t gf3_add(input trit_t a, input trit_t b);
        logic signed [2:0] s;
        s = {a[1], a} + {b[1], b};
        if (s > 3'sd1) begin
            s = s - 3'sd3;
        end
        else if (s < -3'sd1) begin
            s = s + 3'sd3;
        end
        return trit_t'(s[1:0]);
    endfunction

endpackage

FILE: src/ttl_cfg.sv
// configuration register file with apb-style access
// depends on ttl_pkg
module ttl_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ttl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output ttl_pkg::cfg_t               cfg
);
    import ttl_pkg::*;

    logic [LEN_W-1:0] in_len_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             bias_en_reg;
    logic             trop_reg;
    trit_t            rate_reg;
    logic             wr_en;
    reg_idx_t         idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_len_reg  <= LEN_W'(MAX_INPUTS);
            out_len_reg <= LEN_W'(MAX_OUTPUTS);
            bias_en_reg <= 1'b0;
            trop_reg    <= 1'b0;
            rate_reg    <= 2'sb01;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_INPUT_LENGTH:  in_len_reg  <= pwdata[LEN_W-1:0];
                REG_OUTPUT_LENGTH: out_len_reg <= pwdata[LEN_W-1:0];
                REG_BIAS_ENABLE:   bias_en_reg <= pwdata[0];
                REG_TROPICAL_MODE: trop_reg    <= pwdata[0];
                REG_LEARNING_RATE: rate_reg    <= trit_decode(pwdata[1:0]);
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            REG_INPUT_LENGTH:  prdata = 32'(in_len_reg);
            REG_OUTPUT_LENGTH: prdata = 32'(out_len_reg);
            REG_BIAS_ENABLE:   prdata = 32'(bias_en_reg);
            REG_TROPICAL_MODE: prdata = 32'(trop_reg);
            REG_LEARNING_RATE: prdata = {{30{rate_reg[1]}}, rate_reg};
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.rows     = (in_len_reg > LEN_W'(MAX_INPUTS)) ? LEN_W'(MAX_INPUTS) : in_len_reg;
        cfg.cols     = (out_len_reg > LEN_W'(MAX_OUTPUTS)) ? LEN_W'(MAX_OUTPUTS) : out_len_reg;
        cfg.bias_en  = bias_en_reg;
        cfg.tropical = trop_reg;
        cfg.rate     = rate_reg;
    end

endmodule

FILE: src/ttl_front.sv
// front end: takes input transfers and decodes them into queue entries
// depends on ttl_pkg
module ttl_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ttl_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    input  logic                           s_tlast,
    input  logic                           q_full,
    input  logic                           clearing,
    output logic                           push,
    output ttl_pkg::op_t                   op
);
    import ttl_pkg::*;

    logic [7:0] delta;

    assign s_tready = !q_full && !clearing;
    assign push     = s_tvalid && s_tready;
    assign delta    = s_tdata[21:14];

    always_comb
    begin
        op.cmd        = cmd_t'(s_tuser);
        op.row        = s_tdata[5:0];
        op.col        = s_tdata[11:6];
        op.trit       = trit_decode(s_tdata[13:12]);
        op.last       = s_tlast;
        op.delta_zero = (delta == 8'd0);
        op.delta_neg  = delta[7];
    end

endmodule

FILE: src/ttl_fifo.sv
// short queue of decoded commands between front and back
// depends on ttl_pkg
module ttl_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  ttl_pkg::op_t push_op,
    input  logic         pop,
    output logic         full,
    output logic         head_vld,
    output ttl_pkg::op_t head_op
);
    import ttl_pkg::*;

    op_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   cnt_reg;

    assign full     = (cnt_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign head_vld = (cnt_reg != '0);
    assign head_op  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: src/ttl_back.sv
// back end: weight, bias and input stores, forward pass, hebbian update, result register
// depends on ttl_pkg
module ttl_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ttl_pkg::cfg_t                   cfg,
    input  logic                            head_vld,
    input  ttl_pkg::op_t                    head_op,
    output logic                            pop,
    output logic                            clearing,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ttl_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);
    import ttl_pkg::*;

    localparam int WDEPTH = MAX_INPUTS * MAX_OUTPUTS;

    state_t state_reg, state_next;

    // stores
    trit_t w_mem [WDEPTH];
    trit_t b_mem [MAX_OUTPUTS];
    trit_t iv_mem [MAX_INPUTS];
    logic [MAX_OUTPUTS-1:0] b_vld_reg;
    logic [MAX_INPUTS-1:0]  iv_vld_reg;

    trit_t w_rdata_reg, b_rdata_reg, iv_rdata_reg;
    logic  b_rvld_reg, iv_rvld_reg;

    logic               w_we;
    logic [WADDR_W-1:0] w_waddr;
    trit_t              w_wdata;
    logic [WADDR_W-1:0] w_raddr;
    logic               b_we;
    logic               iv_we;
    logic [ROW_W-1:0]   iv_waddr;

    // control and datapath registers
    logic [WADDR_W-1:0] clr_reg, clr_next;
    logic [LEN_W-1:0]   i_reg, i_next;
    logic [LEN_W-1:0]   j_reg, j_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [LEN_W-1:0]   loaded_reg, loaded_next;
    logic               p_vld_reg, p_vld_next;
    logic [WADDR_W-1:0] p_addr_reg, p_addr_next;
    logic signed [7:0]  sum_reg, sum_next;
    logic signed [2:0]  max_reg, max_next;
    trit_t              sgn_reg, sgn_next;
    logic [CHG_W-1:0]   chg_reg, chg_next;

    logic               out_vld_reg, out_vld_next;
    logic               out_kind_reg, out_kind_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    trit_t              out_trit_reg, out_trit_next;
    logic [CHG_W-1:0]   out_chg_reg, out_chg_next;
    logic               out_last_reg, out_last_next;

    // derived values
    logic [LEN_W-1:0]  n_rows;
    logic              out_free;
    trit_t             in_t, b_t;
    logic signed [3:0] prod;
    logic signed [2:0] tsum;
    logic signed [3:0] dprod;
    logic signed [7:0] fsum;
    logic signed [2:0] fmax;
    trit_t             fwd_trit;
    logic [LEN_W-1:0]  cnt_after;

    assign n_rows   = (loaded_reg < cfg.rows) ? loaded_reg : cfg.rows;
    assign out_free = !out_vld_reg || m_tready;
    assign clearing = (state_reg == ST_CLEAR);
    assign in_t     = iv_rvld_reg ? iv_rdata_reg : trit_t'(2'sb00);
    assign b_t      = b_rvld_reg ? b_rdata_reg : trit_t'(2'sb00);
    assign prod     = in_t * w_rdata_reg;
    assign tsum     = {in_t[1], in_t} + {w_rdata_reg[1], w_rdata_reg};
    assign dprod    = sgn_reg * in_t;
    assign cnt_after = (cnt_reg < LEN_W'(MAX_INPUTS)) ? cnt_reg + 1'b1 : cnt_reg;
    assign w_raddr  = {i_reg[ROW_W-1:0], j_reg[COL_W-1:0]};

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_chg_reg, out_trit_reg, out_col_reg};

    // column result from the finished accumulators
    always_comb
    begin
        fsum = sum_reg + (cfg.bias_en ? 8'({{6{b_t[1]}}, b_t}) : 8'sd0);
        fmax = max_reg;
        if (cfg.bias_en && ($signed({b_t[1], b_t}) > fmax))
        begin
            fmax = {b_t[1], b_t};
        end
        if (cfg.tropical)
        begin
            if (fmax > 3'sd1)
            begin
                fwd_trit = 2'sb01;
            end
            else if (fmax < -3'sd1)
            begin
                fwd_trit = 2'sb11;
            end
            else
            begin
                fwd_trit = fmax[1:0];
            end
        end
        else
        begin
            if (fsum > 8'sd0)
            begin
                fwd_trit = 2'sb01;
            end
            else if (fsum < 8'sd0)
            begin
                fwd_trit = 2'sb11;
            end
            else
            begin
                fwd_trit = 2'sb00;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_vld)
                begin
                    if (head_op.cmd == CMD_INPUT && head_op.last && cfg.cols != '0)
                    begin
                        state_next = ST_FWD_COL;
                    end
                    else if (head_op.cmd == CMD_HEBBIAN)
                    begin
                        if (head_op.delta_zero || n_rows == '0 || cfg.cols == '0)
                        begin
                            state_next = ST_HEB_OUT;
                        end
                        else
                        begin
                            state_next = ST_HEB_RUN;
                        end
                    end
                end
            end
            ST_FWD_COL:
            begin
                state_next = ST_FWD_ROW;
            end
            ST_FWD_ROW:
            begin
                if (i_reg == n_rows && !p_vld_reg)
                begin
                    state_next = ST_FWD_OUT;
                end
            end
            ST_FWD_OUT:
            begin
                if (out_free)
                begin
                    state_next = (j_reg + 1'b1 == cfg.cols) ? ST_IDLE : ST_FWD_COL;
                end
            end
            ST_HEB_RUN:
            begin
                if (j_reg == cfg.cols && !p_vld_reg)
                begin
                    state_next = ST_HEB_OUT;
                end
            end
            ST_HEB_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pop          = 1'b0;
        w_we         = 1'b0;
        w_waddr      = p_addr_reg;
        w_wdata      = gf3_add(w_rdata_reg, dprod[1:0]);
        b_we         = 1'b0;
        iv_we        = 1'b0;
        iv_waddr     = cnt_reg[ROW_W-1:0];
        clr_next     = clr_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        loaded_next  = loaded_reg;
        p_vld_next   = 1'b0;
        p_addr_next  = p_addr_reg;
        sum_next     = sum_reg;
        max_next     = max_reg;
        sgn_next     = sgn_reg;
        chg_next     = chg_reg;
        out_vld_next = out_vld_reg && !m_tready;
        out_kind_next = out_kind_reg;
        out_col_next  = out_col_reg;
        out_trit_next = out_trit_reg;
        out_chg_next  = out_chg_reg;
        out_last_next = out_last_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                w_we     = 1'b1;
                w_waddr  = clr_reg;
                w_wdata  = 2'sb00;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (head_vld)
                begin
                    pop = 1'b1;
                    unique case (head_op.cmd)
                        CMD_WR_WEIGHT:
                        begin
                            if ({1'b0, head_op.row} < cfg.rows && {1'b0, head_op.col} < cfg.cols)
                            begin
                                w_we    = 1'b1;
                                w_waddr = {head_op.row, head_op.col};
                                w_wdata = head_op.trit;
                            end
                        end
                        CMD_WR_BIAS:
                        begin
                            b_we = cfg.bias_en && ({1'b0, head_op.col} < cfg.cols);
                        end
                        CMD_INPUT:
                        begin
                            iv_we = (cnt_reg < LEN_W'(MAX_INPUTS));
                            if (head_op.last)
                            begin
                                loaded_next = cnt_after;
                                cnt_next    = '0;
                                j_next      = '0;
                            end
                            else
                            begin
                                cnt_next = cnt_after;
                            end
                        end
                        CMD_HEBBIAN:
                        begin
                            sgn_next = head_op.delta_neg ? trit_t'(-cfg.rate) : cfg.rate;
                            i_next   = '0;
                            j_next   = '0;
                            chg_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FWD_COL:
            begin
                i_next   = '0;
                sum_next = '0;
                max_next = -3'sd2;
            end
            ST_FWD_ROW:
            begin
                if (i_reg < n_rows)
                begin
                    p_vld_next = 1'b1;
                    i_next     = i_reg + 1'b1;
                end
                if (p_vld_reg)
                begin
                    sum_next = sum_reg + 8'(prod);
                    if (tsum > max_reg)
                    begin
                        max_next = tsum;
                    end
                end
            end
            ST_FWD_OUT:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = 1'b0;
                    out_col_next  = j_reg[COL_W-1:0];
                    out_trit_next = fwd_trit;
                    out_chg_next  = '0;
                    out_last_next = (j_reg + 1'b1 == cfg.cols);
                    j_next        = j_reg + 1'b1;
                end
            end
            ST_HEB_RUN:
            begin
                if (j_reg < cfg.cols)
                begin
                    p_vld_next  = 1'b1;
                    p_addr_next = w_raddr;
                    if (i_reg + 1'b1 == n_rows)
                    begin
                        i_next = '0;
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                if (p_vld_reg)
                begin
                    w_we = 1'b1;
                    if (dprod != 4'sd0)
                    begin
                        chg_next = chg_reg + 1'b1;
                    end
                end
            end
            ST_HEB_OUT:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_kind_next = 1'b1;
                    out_col_next  = '0;
                    out_trit_next = 2'sb00;
                    out_chg_next  = chg_reg;
                    out_last_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_waddr] <= w_wdata;
        end
        w_rdata_reg <= w_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[head_op.col] <= head_op.trit;
        end
        b_rdata_reg <= b_mem[j_reg[COL_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (iv_we)
        begin
            iv_mem[iv_waddr] <= head_op.trit;
        end
        iv_rdata_reg <= iv_mem[i_reg[ROW_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg   <= '0;
            iv_vld_reg  <= '0;
            b_rvld_reg  <= 1'b0;
            iv_rvld_reg <= 1'b0;
        end
        else
        begin
            if (b_we)
            begin
                b_vld_reg[head_op.col] <= 1'b1;
            end
            if (iv_we)
            begin
                iv_vld_reg[iv_waddr] <= 1'b1;
            end
            b_rvld_reg  <= b_vld_reg[j_reg[COL_W-1:0]];
            iv_rvld_reg <= iv_vld_reg[i_reg[ROW_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
            loaded_reg  <= '0;
            p_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            cnt_reg     <= cnt_next;
            loaded_reg  <= loaded_next;
            p_vld_reg   <= p_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_addr_reg   <= p_addr_next;
        sum_reg      <= sum_next;
        max_reg      <= max_next;
        sgn_reg      <= sgn_next;
        chg_reg      <= chg_next;
        out_kind_reg <= out_kind_next;
        out_col_reg  <= out_col_next;
        out_trit_reg <= out_trit_next;
        out_chg_reg  <= out_chg_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: src/ternary_linear_layer_engine_top.sv
// top level of the ternary linear layer engine
// depends on ttl_pkg, ttl_cfg, ttl_front, ttl_fifo and ttl_back
module ternary_linear_layer_engine_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ttl_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ttl_pkg::IN_TDATA_W-1:0]  s_tdata,  // row_index, column_index, trit_value, delta
    input  logic [1:0]                      s_tuser,  // command
    input  logic                            s_tlast,  // last_element
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ttl_pkg::OUT_TDATA_W-1:0] m_tdata,  // out_column, out_trit, changed_cells
    output logic                            m_tuser,  // result_kind
    output logic                            m_tlast   // last_result
);
    // A 64 by 64 ternary weight matrix with a bias trit per column. Commands
    // arrive on the s_ stream, are decoded by the front end and wait in a
    // four-entry queue, so the input side keeps taking transfers while the
    // back end works or a result waits in the output register, until the
    // queue is full. Weight writes, bias writes and input elements are
    // executed in the idle state as they leave the queue. The last input
    // element starts a forward pass: each column reads one weight per cycle
    // from the weight memory over rows_used rows, rows_used being the smaller
    // of the loaded element count and input_length, and each column result
    // waits while the output register is full. A Hebbian update reads and
    // writes back one weight per cycle, and its result likewise waits on the
    // output register. After reset the back end sweeps the weight memory to
    // zero; s_tready stays low during that sweep, configuration writes are
    // taken at any time. Results carry the column in out_column and the
    // trit in out_trit; a Hebbian result sets tuser and reports changed_cells.

    import ttl_pkg::*;

    cfg_t cfg;
    op_t  push_op;
    op_t  head_op;
    logic push;
    logic pop;
    logic q_full;
    logic head_vld;
    logic clearing;

    // register file
    ttl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // decode of incoming transfers
    ttl_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .clearing (clearing),
        .push     (push),
        .op       (push_op)
    );

    // command queue between the two halves
    ttl_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .full     (q_full),
        .head_vld (head_vld),
        .head_op  (head_op)
    );

    // execution, stores and result register
    ttl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .head_vld (head_vld),
        .head_op  (head_op),
        .pop      (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
